[rtl/rc5vbd_pkg.sv]
`default_nettype none

package rc5vbd_pkg;

    localparam int KEY_LEN_W         = 6;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int WORD_W            = 32;
    localparam int STATUS_W          = 2;
    localparam int MAX_KEY_BYTES_DEF = 32;

    localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;
    localparam logic [WORD_W-1:0] TWEAK   = 32'h63a72efb;
    localparam logic [4:0]        MIX_ROT = 5'd3;

    localparam logic OP_EXPAND  = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DECRYPTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXPANDED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_KEY    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_0_7   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_8_15  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_16_23 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_24_31 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_MIX_A,
        ST_MIX_B,
        ST_DEC_LOAD,
        ST_DEC_ROUND,
        ST_DEC_END
    } state_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input logic [4:0] s);
        logic [2*WORD_W-1:0] d;
        d = {x, x} << s;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input logic [4:0] s);
        logic [2*WORD_W-1:0] d;
        d = {x, x} >> s;
        return d[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/rc5_variant_block_decrypt.sv]
`default_nettype none
// RC5-32 variant block decryptor with on-chip key schedule.
// Configure key_len and the four key byte registers through cfg_we/cfg_index/cfg_data
// while the block is idle; any write to those registers clears the key-ready flag.
// Issue a command by raising start while busy is low, with operation, word_a, word_b
// and final_block on the same edge. Each command returns one word on plain_a,
// plain_b, final_out and status, shown for one cycle with done high.
// Expand (operation 0): a fill pass writes t = 4L+2 subkeys, then 3t mixing steps, each
// through states MIX_A and MIX_B, run through the single subkey RAM port pair; done rises
// after the last mixing step.
// Decrypt (operation 1): a load state, one round per cycle for 2L rounds through the
// shared round unit and the dual-read subkey RAM, then a final subtract state before done
// rises. Without a scheduled key done rises on the next cycle with status 2 and zero data.
// A new command is taken in the cycle done is shown. busy stays high while working.
// Reset clears the control state and the key-ready flag and sets key_len to 16; the
// subkey RAM holds no meaning until the next expand. The receiver cannot stall: each
// result is shown for exactly one cycle.
module rc5_variant_block_decrypt #(
    parameter int MAX_KEY_BYTES = rc5vbd_pkg::MAX_KEY_BYTES_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    start,
    output logic                                   busy,
    input  wire                                    operation,
    input  wire  [rc5vbd_pkg::WORD_W-1:0]          word_a,
    input  wire  [rc5vbd_pkg::WORD_W-1:0]          word_b,
    input  wire                                    final_block,
    input  wire                                    cfg_we,
    input  wire  [rc5vbd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [rc5vbd_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                   done,
    output logic [rc5vbd_pkg::WORD_W-1:0]          plain_a,
    output logic [rc5vbd_pkg::WORD_W-1:0]          plain_b,
    output logic                                   final_out,
    output logic [rc5vbd_pkg::STATUS_W-1:0]        status
);

    localparam int WW      = rc5vbd_pkg::WORD_W;
    localparam int LW      = rc5vbd_pkg::KEY_LEN_W;
    localparam int SUBKEYS = 4 * MAX_KEY_BYTES + 2;
    localparam int KW      = (MAX_KEY_BYTES + 3) / 4;
    localparam int AW      = $clog2(SUBKEYS);
    localparam int CW      = $clog2(3 * SUBKEYS);
    localparam int KIW     = (KW > 1) ? $clog2(KW) : 1;

    rc5vbd_pkg::state_t state_reg, state_next;

    logic [LW-1:0]    key_len_reg, key_len_next;
    logic [63:0]      key0_reg, key0_next;
    logic [63:0]      key1_reg, key1_next;
    logic [63:0]      key2_reg, key2_next;
    logic [63:0]      key3_reg, key3_next;
    logic             key_ready_reg, key_ready_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    si_reg, si_next;
    logic [KIW-1:0]   ki_reg, ki_next;
    logic [AW-1:0]    k_reg, k_next;
    logic [WW-1:0]    a_reg, a_next;
    logic [WW-1:0]    b_reg, b_next;
    logic [WW-1:0]    fill_reg, fill_next;
    logic             fin_reg, fin_next;
    logic [WW-1:0]    kw_reg [KW];
    logic [WW-1:0]    kw_next [KW];

    logic                              done_reg, done_next;
    logic [WW-1:0]                     plain_a_reg, plain_a_next;
    logic [WW-1:0]                     plain_b_reg, plain_b_next;
    logic                              final_out_reg, final_out_next;
    logic [rc5vbd_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic [WW-1:0] sub_mem [SUBKEYS];
    logic [WW-1:0] rd0_reg, rd1_reg;
    logic          mem_we;
    logic [AW-1:0] waddr, raddr0, raddr1;
    logic [WW-1:0] wdata;

    logic [LW-1:0]  n_eff;
    logic [CW-1:0]  fill_last;
    logic [CW-1:0]  mix_last;
    logic [CW-1:0]  round_last;
    logic [AW-1:0]  sub_last;
    logic [KIW-1:0] kw_last;
    logic [255:0]   key_flat;
    logic           accept;

    assign busy      = (state_reg != rc5vbd_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign plain_a   = plain_a_reg;
    assign plain_b   = plain_b_reg;
    assign final_out = final_out_reg;
    assign status    = status_reg;

    assign key_flat = {key3_reg, key2_reg, key1_reg, key0_reg};

    always_comb
    begin
        if (key_len_reg == '0)
        begin
            n_eff = LW'(1);
        end
        else if (key_len_reg > LW'(MAX_KEY_BYTES))
        begin
            n_eff = LW'(MAX_KEY_BYTES);
        end
        else
        begin
            n_eff = key_len_reg;
        end
    end

    assign fill_last  = CW'({n_eff, 2'b01});
    assign sub_last   = AW'({n_eff, 2'b01});
    assign mix_last   = CW'((CW'({n_eff, 2'b10}) << 1) + CW'({n_eff, 2'b10}) - CW'(1));
    assign round_last = CW'({n_eff, 1'b0} - (LW + 1)'(1));
    assign kw_last    = KIW'((n_eff - LW'(1)) >> 2);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rc5vbd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == rc5vbd_pkg::OP_EXPAND)
                    begin
                        state_next = rc5vbd_pkg::ST_FILL;
                    end
                    else if (key_ready_reg)
                    begin
                        state_next = rc5vbd_pkg::ST_DEC_LOAD;
                    end
                end
            end
            rc5vbd_pkg::ST_FILL:
            begin
                if (cnt_reg == fill_last)
                begin
                    state_next = rc5vbd_pkg::ST_MIX_A;
                end
            end
            rc5vbd_pkg::ST_MIX_A:
            begin
                state_next = rc5vbd_pkg::ST_MIX_B;
            end
            rc5vbd_pkg::ST_MIX_B:
            begin
                state_next = (cnt_reg == mix_last) ? rc5vbd_pkg::ST_IDLE
                                                   : rc5vbd_pkg::ST_MIX_A;
            end
            rc5vbd_pkg::ST_DEC_LOAD:
            begin
                state_next = rc5vbd_pkg::ST_DEC_ROUND;
            end
            rc5vbd_pkg::ST_DEC_ROUND:
            begin
                if (cnt_reg == round_last)
                begin
                    state_next = rc5vbd_pkg::ST_DEC_END;
                end
            end
            rc5vbd_pkg::ST_DEC_END:
            begin
                state_next = rc5vbd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rc5vbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic [WW-1:0] sum;
        logic [WW-1:0] w;
        logic [WW-1:0] b_rnd;

        key_len_next   = key_len_reg;
        key0_next      = key0_reg;
        key1_next      = key1_reg;
        key2_next      = key2_reg;
        key3_next      = key3_reg;
        key_ready_next = key_ready_reg;
        cnt_next       = cnt_reg;
        si_next        = si_reg;
        ki_next        = ki_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        fill_next      = fill_reg;
        fin_next       = fin_reg;
        kw_next        = kw_reg;
        done_next      = 1'b0;
        plain_a_next   = plain_a_reg;
        plain_b_next   = plain_b_reg;
        final_out_next = final_out_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        waddr          = si_reg;
        wdata          = a_reg;
        raddr0         = si_reg;
        raddr1         = '0;
        sum            = a_reg + b_reg;
        w              = '0;
        b_rnd          = '0;

        unique case (state_reg)
            rc5vbd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    fin_next = final_block;
                    cnt_next = '0;
                    if (operation == rc5vbd_pkg::OP_EXPAND)
                    begin
                        a_next    = '0;
                        b_next    = '0;
                        si_next   = '0;
                        ki_next   = '0;
                        fill_next = rc5vbd_pkg::MAGIC_P;
                        for (int i = 0; i < KW; i++)
                        begin
                            w = '0;
                            for (int j = 0; j < 4; j++)
                            begin
                                if ((4 * i + j) < int'(n_eff))
                                begin
                                    w[8*j +: 8] = key_flat[32*i + 8*j +: 8];
                                end
                            end
                            kw_next[i] = w;
                        end
                    end
                    else if (key_ready_reg)
                    begin
                        a_next = word_a;
                        b_next = word_b;
                        k_next = sub_last;
                    end
                    else
                    begin
                        done_next      = 1'b1;
                        plain_a_next   = '0;
                        plain_b_next   = '0;
                        final_out_next = final_block;
                        status_next    = rc5vbd_pkg::STATUS_NO_KEY;
                    end
                end
            end
            rc5vbd_pkg::ST_FILL:
            begin
                mem_we    = 1'b1;
                waddr     = cnt_reg[AW-1:0];
                wdata     = fill_reg;
                fill_next = fill_reg + rc5vbd_pkg::MAGIC_Q;
                cnt_next  = (cnt_reg == fill_last) ? '0 : cnt_reg + CW'(1);
            end
            rc5vbd_pkg::ST_MIX_A:
            begin
                a_next  = rc5vbd_pkg::rotl(rd0_reg + sum, rc5vbd_pkg::MIX_ROT);
                mem_we  = 1'b1;
                waddr   = si_reg;
                wdata   = a_next;
                si_next = (si_reg == sub_last) ? '0 : si_reg + AW'(1);
            end
            rc5vbd_pkg::ST_MIX_B:
            begin
                b_next          = rc5vbd_pkg::rotl(kw_reg[ki_reg] + sum, sum[4:0]);
                kw_next[ki_reg] = b_next;
                ki_next         = (ki_reg == kw_last) ? '0 : ki_reg + KIW'(1);
                if (cnt_reg == mix_last)
                begin
                    key_ready_next = 1'b1;
                    done_next      = 1'b1;
                    plain_a_next   = '0;
                    plain_b_next   = '0;
                    final_out_next = fin_reg;
                    status_next    = rc5vbd_pkg::STATUS_EXPANDED;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            rc5vbd_pkg::ST_DEC_LOAD:
            begin
                raddr0 = k_reg;
                raddr1 = k_reg - AW'(1);
            end
            rc5vbd_pkg::ST_DEC_ROUND:
            begin
                b_rnd  = rc5vbd_pkg::rotr(b_reg - rd0_reg, a_reg[4:0]) ^ a_reg;
                a_next = rc5vbd_pkg::rotr((a_reg - rd1_reg) ^ rc5vbd_pkg::TWEAK, b_rnd[4:0])
                         ^ b_rnd;
                b_next = b_rnd;
                k_next = k_reg - AW'(2);
                raddr0 = k_reg - AW'(2);
                raddr1 = k_reg - AW'(3);
                cnt_next = cnt_reg + CW'(1);
            end
            rc5vbd_pkg::ST_DEC_END:
            begin
                done_next      = 1'b1;
                plain_a_next   = a_reg - rd1_reg;
                plain_b_next   = b_reg - rd0_reg;
                final_out_next = fin_reg;
                status_next    = rc5vbd_pkg::STATUS_DECRYPTED;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                rc5vbd_pkg::REG_KEY_LEN:
                begin
                    key_len_next   = cfg_data[LW-1:0];
                    key_ready_next = 1'b0;
                end
                rc5vbd_pkg::REG_KEY_0_7:
                begin
                    key0_next      = cfg_data;
                    key_ready_next = 1'b0;
                end
                rc5vbd_pkg::REG_KEY_8_15:
                begin
                    key1_next      = cfg_data;
                    key_ready_next = 1'b0;
                end
                rc5vbd_pkg::REG_KEY_16_23:
                begin
                    key2_next      = cfg_data;
                    key_ready_next = 1'b0;
                end
                rc5vbd_pkg::REG_KEY_24_31:
                begin
                    key3_next      = cfg_data;
                    key_ready_next = 1'b0;
                end
                default:
                begin
                    key_ready_next = key_ready_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc5vbd_pkg::ST_IDLE;
            key_len_reg   <= LW'(16);
            key0_reg      <= '0;
            key1_reg      <= '0;
            key2_reg      <= '0;
            key3_reg      <= '0;
            key_ready_reg <= 1'b0;
            cnt_reg       <= '0;
            si_reg        <= '0;
            ki_reg        <= '0;
            k_reg         <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_len_reg   <= key_len_next;
            key0_reg      <= key0_next;
            key1_reg      <= key1_next;
            key2_reg      <= key2_next;
            key3_reg      <= key3_next;
            key_ready_reg <= key_ready_next;
            cnt_reg       <= cnt_next;
            si_reg        <= si_next;
            ki_reg        <= ki_next;
            k_reg         <= k_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        fill_reg      <= fill_next;
        fin_reg       <= fin_next;
        kw_reg        <= kw_next;
        plain_a_reg   <= plain_a_next;
        plain_b_reg   <= plain_b_next;
        final_out_reg <= final_out_next;
        status_reg    <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sub_mem[waddr] <= wdata;
        end
        rd0_reg <= sub_mem[raddr0];
        rd1_reg <= sub_mem[raddr1];
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rc5vbd_pkg::*;

    localparam int WORDS_TARGET = 450;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 80;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic              fin;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]   pa;
        logic [WORD_W-1:0]   pb;
        logic                fin;
        logic [STATUS_W-1:0] st;
    } result_t;

    typedef enum logic {ROW_REG, ROW_CMD} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  op;
        logic [WORD_W-1:0]     a;
        logic [WORD_W-1:0]     b;
        logic                  fin;
        logic                  typed;
        logic [STATUS_W-1:0]   want_st;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   operation;
    logic [WORD_W-1:0]      word_a;
    logic [WORD_W-1:0]      word_b;
    logic                   final_block;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   done;
    logic [WORD_W-1:0]      plain_a;
    logic [WORD_W-1:0]      plain_b;
    logic                   final_out;
    logic [STATUS_W-1:0]    status;

    always #5 clk = ~clk;

    rc5_variant_block_decrypt uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .word_a      (word_a),
        .word_b      (word_b),
        .final_block (final_block),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .plain_a     (plain_a),
        .plain_b     (plain_b),
        .final_out   (final_out),
        .status      (status)
    );

    // shadow of the key schedule and configuration
    logic [WORD_W-1:0]     sched_tab [0:4*MAX_KEY_BYTES_DEF+1];
    logic [WORD_W-1:0]     key_work  [0:(MAX_KEY_BYTES_DEF+3)/4-1];
    logic                  key_set   = 1'b0;
    logic [KEY_LEN_W-1:0]  m_key_len = 6'd16;
    logic [CFG_DATA_W-1:0] m_key_reg [0:3] = '{default: '0};

    result_t awaited [$];

    int faults     = 0;
    int sent       = 0;
    int n_expand   = 0;
    int n_decrypt  = 0;
    int n_nokey    = 0;
    int reg_writes = 0;
    int checked    = 0;
    int quiet      = 0;
    bit idle_allowed = 1'b1;

    row_t directed_plan [$] = '{
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h0, 32'h0, 1'b0, 1'b1, STATUS_NO_KEY},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, '1, '1, 1'b1, 1'b1, STATUS_NO_KEY},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_EXPAND, 32'h0, 32'h0, 1'b1, 1'b1, STATUS_EXPANDED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, '1, '1, 1'b1, 1'b0, STATUS_DECRYPTED},
        '{ROW_REG, REG_KEY_LEN, 64'd1, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h12345678, 32'h9abcdef0, 1'b0, 1'b1,
          STATUS_NO_KEY},
        '{ROW_REG, REG_KEY_0_7, '1, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_EXPAND, '1, 32'h0, 1'b0, 1'b1, STATUS_EXPANDED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h80000000, 32'h00000001, 1'b1, 1'b0,
          STATUS_DECRYPTED},
        '{ROW_REG, REG_UNUSED_LO, 64'hdeadbeef_cafef00d, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0,
          STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h00000001, 32'h80000000, 1'b0, 1'b0,
          STATUS_DECRYPTED},
        '{ROW_REG, REG_KEY_LEN, 64'd32, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_REG, REG_KEY_8_15, 64'h01234567_89abcdef, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0,
          STATUS_DECRYPTED},
        '{ROW_REG, REG_KEY_16_23, '1, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_REG, REG_KEY_24_31, 64'h80000000_00000001, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0,
          STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b1, STATUS_EXPANDED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h0, '1, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, '1, 32'h0, 1'b1, 1'b0, STATUS_DECRYPTED},
        '{ROW_REG, REG_KEY_LEN, 64'd0, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b1, STATUS_EXPANDED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'hdeadbeef, 32'h0badf00d, 1'b1, 1'b0,
          STATUS_DECRYPTED},
        '{ROW_REG, REG_KEY_LEN, 64'd63, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b1, STATUS_EXPANDED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h13579bdf, 32'h2468ace0, 1'b0, 1'b0,
          STATUS_DECRYPTED},
        '{ROW_REG, REG_KEY_0_7, 64'd0, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_REG, REG_UNUSED_HI, '1, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h0, 32'h0, 1'b1, 1'b1, STATUS_NO_KEY},
        '{ROW_REG, REG_KEY_LEN, 64'd5, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b0, STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_EXPAND, 32'h0, 32'h0, 1'b0, 1'b1, STATUS_EXPANDED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h5a5a5a5a, 32'ha5a5a5a5, 1'b0, 1'b0,
          STATUS_DECRYPTED},
        '{ROW_CMD, REG_KEY_LEN, 64'd0, OP_DECRYPT, 32'h0000001f, 32'h00000020, 1'b1, 1'b0,
          STATUS_DECRYPTED}
    };

    function automatic logic [WORD_W-1:0] spin_l(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] s);
        if (s == 5'd0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [WORD_W-1:0] spin_r(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] s);
        if (s == 5'd0)
            return x;
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic int unsigned used_bytes();
        if (m_key_len == 0)
            return 1;
        if (m_key_len > MAX_KEY_BYTES_DEF)
            return MAX_KEY_BYTES_DEF;
        return m_key_len;
    endfunction

    function automatic void schedule_keys();
        int unsigned n, t, c, mix, si, ki, i, k, idx;
        logic [WORD_W-1:0] a, b, w;
        n = used_bytes();
        t = 4 * n + 2;
        c = (n - 1) / 4 + 1;
        for (i = 0; i < c; i++)
        begin
            w = '0;
            for (k = 0; k < 4; k++)
            begin
                idx = 4 * i + k;
                if (idx < n)
                    w[8*k +: 8] = m_key_reg[idx / 8][8*(idx % 8) +: 8];
            end
            key_work[i] = w;
        end
        sched_tab[0] = MAGIC_P;
        for (i = 1; i < t; i++)
            sched_tab[i] = sched_tab[i-1] + MAGIC_Q;
        mix = 3 * ((t > c) ? t : c);
        a = '0;
        b = '0;
        si = 0;
        ki = 0;
        for (i = 0; i < mix; i++)
        begin
            a = spin_l(sched_tab[si] + a + b, MIX_ROT);
            sched_tab[si] = a;
            b = spin_l(key_work[ki] + a + b, a[4:0] + b[4:0]);
            key_work[ki] = b;
            si = (si + 1 == t) ? 0 : si + 1;
            ki = (ki + 1 == c) ? 0 : ki + 1;
        end
        key_set = 1'b1;
    endfunction

    function automatic void decrypt_block(input logic [WORD_W-1:0] ca, cb,
                                          output logic [WORD_W-1:0] pa, pb);
        int unsigned n, k, r;
        logic [WORD_W-1:0] a, b;
        a = ca;
        b = cb;
        n = used_bytes();
        k = 4 * n + 1;
        for (r = 0; r < 2 * n; r++)
        begin
            b = spin_r(b - sched_tab[k], a[4:0]) ^ a;
            a = spin_r((a - sched_tab[k-1]) ^ TWEAK, b[4:0]) ^ b;
            k -= 2;
        end
        pb = b - sched_tab[1];
        pa = a - sched_tab[0];
    endfunction

    function automatic result_t predict_word(input cmd_t c);
        result_t r;
        r = '{pa: '0, pb: '0, fin: c.fin, st: STATUS_DECRYPTED};
        if (c.op == OP_EXPAND)
        begin
            schedule_keys();
            r.st = STATUS_EXPANDED;
        end
        else if (!key_set)
            r.st = STATUS_NO_KEY;
        else
            decrypt_block(c.a, c.b, r.pa, r.pb);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KEY_LEN_W-1:0] pick_len();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll < 7)
            return KEY_LEN_W'($urandom_range(8, 1));
        if (roll < 9)
            return KEY_LEN_W'($urandom_range(32, 9));
        return ($urandom_range(3) == 0) ? 6'd0 : KEY_LEN_W'($urandom_range(63, 32));
    endfunction

    // hold start low until every word has come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (awaited.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_KEY_LEN)
        begin
            m_key_len = val[KEY_LEN_W-1:0];
            key_set   = 1'b0;
        end
        else if (idx <= REG_KEY_24_31)
        begin
            m_key_reg[idx - REG_KEY_0_7] = val;
            key_set = 1'b0;
        end
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_cmd(input cmd_t c, input logic typed, input result_t want);
        int gap;
        result_t r;
        if (idle_allowed && $urandom_range(99) < 34)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(100, 1) : $urandom_range(3, 1);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start       <= 1'b1;
        operation   <= c.op;
        word_a      <= c.a;
        word_b      <= c.b;
        final_block <= c.fin;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_word(c);
        if (c.op == OP_EXPAND)
            n_expand++;
        else if (r.st == STATUS_NO_KEY)
            n_nokey++;
        else
            n_decrypt++;
        awaited.push_back(typed ? want : r);
        sent++;
    endtask

    always @(posedge clk)
    begin : check_words
        result_t want;
        if (rst_n && done)
        begin
            if (awaited.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected word: a=%h b=%h fin=%b status=%0d",
                             plain_a, plain_b, final_out, status);
            end
            else
            begin
                want = awaited.pop_front();
                checked++;
                if (plain_a !== want.pa || plain_b !== want.pb
                    || final_out !== want.fin || status !== want.st)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("word %0d: want a=%h b=%h fin=%b status=%0d, got a=%h b=%h fin=%b status=%0d",
                                 checked, want.pa, want.pb, want.fin, want.st,
                                 plain_a, plain_b, final_out, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        row_t    row;
        cmd_t    c;
        result_t want;
        int      phase_len, i;
        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = OP_EXPAND;
        word_a      = '0;
        word_b      = '0;
        final_block = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_KEY_LEN;
        cfg_data    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[n])
        begin
            row = directed_plan[n];
            if (row.kind == ROW_REG)
            begin
                drain();
                write_reg(row.idx, row.data);
            end
            else
            begin
                c    = '{op: row.op, a: row.a, b: row.b, fin: row.fin};
                want = '{pa: '0, pb: '0, fin: row.fin, st: row.want_st};
                send_cmd(c, row.typed, want);
            end
        end

        while (sent < WORDS_TARGET)
        begin
            drain();
            if ($urandom_range(3) != 0)
                write_reg(REG_KEY_LEN, CFG_DATA_W'(pick_len()));
            if ($urandom_range(1)) write_reg(REG_KEY_0_7, {$urandom, $urandom});
            if ($urandom_range(1)) write_reg(REG_KEY_8_15, {$urandom, $urandom});
            if ($urandom_range(1)) write_reg(REG_KEY_16_23, {$urandom, $urandom});
            if ($urandom_range(1)) write_reg(REG_KEY_24_31, {$urandom, $urandom});
            if ($urandom_range(9) == 0)
                write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                          {$urandom, $urandom});
            phase_len = $urandom_range(40, 10);
            for (i = 0; i < phase_len; i++)
            begin
                idle_allowed = !(sent >= 180 && sent < 300);
                if (i == 0)
                    c.op = ($urandom_range(9) != 0) ? OP_EXPAND : OP_DECRYPT;
                else
                    c.op = ($urandom_range(29) == 0) ? OP_EXPAND : OP_DECRYPT;
                c.a   = pick_word();
                c.b   = pick_word();
                c.fin = (i == phase_len - 1) ? 1'b1 : ($urandom_range(7) == 0);
                send_cmd(c, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d words sent: %0d key schedules, %0d blocks decrypted, %0d refused",
                 sent, n_expand, n_decrypt, n_nokey);
        $display("summary: %0d register writes, %0d results checked, %0d faults",
                 reg_writes, checked, faults);
        if (faults == 0 && awaited.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire

[rc5_variant_block_decrypt.f]
rtl/rc5vbd_pkg.sv
rtl/rc5_variant_block_decrypt.sv
tb/testbench.sv
